[hw/rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

    localparam int MaxBlocks   = 64;
    localparam int IdxW        = 6;
    localparam int LinkW       = 7;
    localparam int AddrW       = 48;
    localparam int SizeW       = 32;
    localparam int FramesW     = 21;
    localparam int FrameShift  = 12;
    localparam int HeaderBytes = 24;
    localparam int AlignBytes  = 16;

    localparam logic [LinkW-1:0] EndOfList = LinkW'(MaxBlocks);

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StZero    = 3'd1;
    localparam logic [2:0] StNoMem   = 3'd2;
    localparam logic [2:0] StNoDesc  = 3'd3;
    localparam logic [2:0] StUnknown = 3'd4;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SizeW-1:0]  request_size;
        logic [AddrW-1:0]  free_address;
    } req_t;

    typedef struct packed {
        logic [AddrW-1:0] result_address;
        logic [2:0]       status;
    } rsp_t;

    // one descriptor entry
    typedef struct packed {
        logic [AddrW-1:0] base;
        logic [SizeW-1:0] size;
        logic             free;
        logic [LinkW-1:0] link;
    } desc_t;

    // descriptor table write request
    typedef struct packed {
        logic            en;
        logic [IdxW-1:0] idx;
        desc_t           data;
    } dwr_t;

endpackage
`default_nettype wire

[hw/rtl/ffha_desc_ram.sv]
`default_nettype none
module ffha_desc_ram (
    input  wire logic                   clk,
    input  wire ffha_pkg::dwr_t         wr,
    input  wire logic [ffha_pkg::IdxW-1:0] raddr,
    output ffha_pkg::desc_t             rdata
);

    ffha_pkg::desc_t mem [ffha_pkg::MaxBlocks];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/first_fit_heap_allocator_core.sv]
// sequence: each descriptor walked passes S_RD and S_CHK; an alloc then goes through S_SPLIT_CHK
// (split check) and S_SPLIT (block write), through S_GROW first when the heap grows; a failed
// free walk ends from S_RD; a zero size or a null free goes from S_IDLE straight to S_OUT
// flow: one transaction at a time; the next request is taken in S_IDLE, once the result has
// been accepted from S_OUT; the descriptor walk through the registered-read table sets the pace
// reset: asynchronous, active low; empty list, no frames used, config registers at defaults
`default_nettype none
module first_fit_heap_allocator_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ffha_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ffha_pkg::rsp_t      out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_GROW, S_SPLIT_CHK, S_SPLIT, S_DONE, S_OUT
    } state_t;

    localparam int AW = ffha_pkg::AddrW;
    localparam int LW = ffha_pkg::LinkW;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            rbase_reg;
    logic [ffha_pkg::FramesW-1:0] rframes_reg;
    logic [ffha_pkg::FramesW-1:0] used_reg, used_next;
    logic [LW-1:0]            head_reg, head_next;
    logic [LW-1:0]            count_reg, count_next;
    logic [LW-1:0]            cur_reg, cur_next;
    logic [LW-1:0]            hops_reg, hops_next;
    logic                     op_reg, op_next;
    logic [33:0]              sz_reg, sz_next;
    logic [AW-1:0]            faddr_reg, faddr_next;
    ffha_pkg::desc_t          blk_reg, blk_next;
    logic [LW-1:0]            blki_reg, blki_next;
    ffha_pkg::rsp_t           rsp_reg, rsp_next;

    ffha_pkg::dwr_t           wr;
    ffha_pkg::desc_t          rd;
    logic [ffha_pkg::IdxW-1:0] raddr;

    // growth arithmetic, in wide temporaries
    logic [34:0]              need;
    logic [22:0]              frames;
    logic [35:0]              bytes;
    logic [49:0]              start;
    logic                     grow_bad;

    ffha_desc_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = rsp_reg;
    assign pready    = 1'b1;

    // config read mux
    always_comb
    begin
        prdata = '0;
        unique case (paddr[3])
            1'b0:    prdata = 64'(rbase_reg);
            default: prdata = 64'(rframes_reg);
        endcase
    end

    always_comb
    begin
        need     = 35'(sz_reg) + 35'(ffha_pkg::HeaderBytes) + 35'(4095);
        frames   = need[34:12];
        bytes    = {1'b0, frames, 12'd0};
        start    = 50'(rbase_reg) + {17'd0, used_reg, 12'd0};
        grow_bad = (24'(used_reg) + 24'(frames) > 24'(rframes_reg))
                 || (bytes - 36'(ffha_pkg::HeaderBytes) > 36'hFFFF_FFFF)
                 || (start + 50'(bytes) > 50'h1_0000_0000_0000);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        hops_next  = hops_reg;
        op_next    = op_reg;
        sz_next    = sz_reg;
        faddr_next = faddr_reg;
        blk_next   = blk_reg;
        blki_next  = blki_reg;
        rsp_next   = rsp_reg;
        wr         = '0;
        raddr      = cur_reg[ffha_pkg::IdxW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.op;
                    sz_next    = (34'(in_data.request_size) + 34'd15) & ~34'd15;
                    faddr_next = in_data.free_address;
                    cur_next   = head_reg;
                    hops_next  = '0;
                    if ((in_data.op == ffha_pkg::OpAlloc && in_data.request_size == '0)
                        || (in_data.op == ffha_pkg::OpFree && in_data.free_address == '0))
                    begin
                        rsp_next   = '{result_address: '0, status: ffha_pkg::StZero};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (cur_reg[LW-1] || hops_reg[LW-1])
                begin
                    if (op_reg == ffha_pkg::OpFree)
                    begin
                        rsp_next   = '{result_address: '0, status: ffha_pkg::StUnknown};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_GROW;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                blk_next  = rd;
                blki_next = cur_reg;
                if (op_reg == ffha_pkg::OpFree)
                begin
                    if (rd.base + AW'(ffha_pkg::HeaderBytes) == faddr_reg)
                    begin
                        wr.en        = 1'b1;
                        wr.idx       = cur_reg[ffha_pkg::IdxW-1:0];
                        wr.data      = rd;
                        wr.data.free = 1'b1;
                        rsp_next     = '{result_address: '0, status: ffha_pkg::StOk};
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        cur_next   = rd.link;
                        hops_next  = hops_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (rd.free && 34'(rd.size) >= sz_reg)
                begin
                    state_next = S_SPLIT_CHK;
                end
                else
                begin
                    cur_next   = rd.link;
                    hops_next  = hops_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_GROW:
            begin
                if (grow_bad)
                begin
                    rsp_next   = '{result_address: '0, status: ffha_pkg::StNoMem};
                    state_next = S_OUT;
                end
                else if (count_reg[LW-1])
                begin
                    rsp_next   = '{result_address: '0, status: ffha_pkg::StNoDesc};
                    state_next = S_OUT;
                end
                else
                begin
                    blk_next.base = start[AW-1:0];
                    blk_next.size = 32'(bytes - 36'(ffha_pkg::HeaderBytes));
                    blk_next.free = 1'b1;
                    blk_next.link = head_reg;
                    blki_next     = count_reg;
                    wr.en         = 1'b1;
                    wr.idx        = count_reg[ffha_pkg::IdxW-1:0];
                    wr.data       = blk_next;
                    head_next     = count_reg;
                    count_next    = count_reg + 1'b1;
                    used_next     = used_reg + frames[ffha_pkg::FramesW-1:0];
                    state_next    = S_SPLIT_CHK;
                end
            end
            S_SPLIT_CHK:
            begin
                if (34'(blk_reg.size) >= sz_reg + 34'(ffha_pkg::HeaderBytes
                    + ffha_pkg::AlignBytes))
                begin
                    if (count_reg[LW-1])
                    begin
                        rsp_next   = '{result_address: '0, status: ffha_pkg::StNoDesc};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // write remainder descriptor
                        wr.en        = 1'b1;
                        wr.idx       = count_reg[ffha_pkg::IdxW-1:0];
                        wr.data.base = blk_reg.base + AW'(ffha_pkg::HeaderBytes)
                                     + AW'(sz_reg);
                        wr.data.size = blk_reg.size - 32'(ffha_pkg::HeaderBytes)
                                     - sz_reg[31:0];
                        wr.data.free = 1'b1;
                        wr.data.link = blk_reg.link;
                        blk_next.size = sz_reg[31:0];
                        blk_next.link = count_reg;
                        count_next    = count_reg + 1'b1;
                        state_next    = S_SPLIT;
                    end
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                wr.en         = 1'b1;
                wr.idx        = blki_reg[ffha_pkg::IdxW-1:0];
                wr.data       = blk_reg;
                wr.data.free  = 1'b0;
                rsp_next      = '{result_address: blk_reg.base + AW'(ffha_pkg::HeaderBytes),
                                  status: ffha_pkg::StOk};
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rbase_reg   <= AW'(1048576);
            rframes_reg <= ffha_pkg::FramesW'(256);
            used_reg    <= '0;
            head_reg    <= ffha_pkg::EndOfList;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[3] == 1'b0)
                begin
                    rbase_reg <= pwdata[AW-1:0];
                end
                else
                begin
                    rframes_reg <= pwdata[ffha_pkg::FramesW-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        hops_reg  <= hops_next;
        op_reg    <= op_next;
        sz_reg    <= sz_next;
        faddr_reg <= faddr_next;
        blk_reg   <= blk_next;
        blki_reg  <= blki_next;
        rsp_reg   <= rsp_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LW'(ffha_pkg::MaxBlocks))
        else $error("descriptor count beyond table");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rsp_reg.status != ffha_pkg::StOk |-> rsp_reg.result_address == '0)
        else $error("failure with address");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GROW && !grow_bad && !count_reg[LW-1] |=> count_reg != '0)
        else $error("grow without descriptor");

endmodule
`default_nettype wire

[dv/tb_first_fit_heap_allocator_core.sv]
`default_nettype none
module tb_first_fit_heap_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int RegRegionBase   = 0;
    localparam int RegRegionFrames = 1;
    localparam int FrameBytes      = 4096;
    localparam longint unsigned AddrMask = 64'hFFFF_FFFF_FFFF;
    localparam int DrainCycles     = 150;

    // heap model plus queue of pending allocator responses
    class heap_scoreboard;
        logic [AddrW-1:0] blk_base [MaxBlocks];
        logic [SizeW-1:0] blk_size [MaxBlocks];
        bit               blk_free [MaxBlocks];
        int               blk_link [MaxBlocks];
        int               head;
        int               used_desc;
        longint unsigned  frames_taken;
        longint unsigned  region_base;
        longint unsigned  region_frames;
        rsp_t             pending_rsp[$];
        int               errors;
        int               checked;
        int               status_seen[8];

        function new();
            head          = MaxBlocks;
            used_desc     = 0;
            frames_taken  = 0;
            region_base   = 1048576;
            region_frames = 256;
            errors        = 0;
            checked       = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_reg(int idx, longint unsigned val);
            if (idx == RegRegionBase)
                region_base = val & AddrMask;
            else
                region_frames = val & 64'h1F_FFFF;
        endfunction

        function rsp_t allocate(longint unsigned req);
            rsp_t            r;
            longint unsigned sz, frames, bytes, start;
            int              cur, blk, rem;
            r   = '0;
            blk = MaxBlocks;
            if (req == 0)
            begin
                r.status = StZero;
                return r;
            end
            sz  = ((req + AlignBytes - 1) / AlignBytes) * AlignBytes;
            cur = head;
            for (int hops = 0; hops < MaxBlocks && cur < MaxBlocks; hops++)
            begin
                if (blk_free[cur] && longint'(blk_size[cur]) >= sz)
                begin
                    blk = cur;
                    break;
                end
                cur = blk_link[cur];
            end
            // nothing fits: grow at the head
            if (blk >= MaxBlocks)
            begin
                frames = (HeaderBytes + sz + FrameBytes - 1) / FrameBytes;
                bytes  = frames * FrameBytes;
                start  = region_base + frames_taken * FrameBytes;
                if (frames_taken + frames > region_frames ||
                    bytes - HeaderBytes > 64'hFFFF_FFFF ||
                    start + bytes > AddrMask + 1)
                begin
                    r.status = StNoMem;
                    return r;
                end
                if (used_desc >= MaxBlocks)
                begin
                    r.status = StNoDesc;
                    return r;
                end
                blk           = used_desc++;
                blk_base[blk] = AddrW'(start & AddrMask);
                blk_size[blk] = SizeW'(bytes - HeaderBytes);
                blk_free[blk] = 1;
                blk_link[blk] = head;
                head          = blk;
                frames_taken  = (frames_taken + frames) & 64'h1F_FFFF;
            end
            // split off the tail when it can hold a header and a minimum block
            if (longint'(blk_size[blk]) >= sz + HeaderBytes + AlignBytes)
            begin
                if (used_desc >= MaxBlocks)
                begin
                    r.status = StNoDesc;
                    return r;
                end
                rem           = used_desc++;
                blk_base[rem] = AddrW'((blk_base[blk] + HeaderBytes + sz) & AddrMask);
                blk_size[rem] = SizeW'(longint'(blk_size[blk]) - sz - HeaderBytes);
                blk_free[rem] = 1;
                blk_link[rem] = blk_link[blk];
                blk_size[blk] = SizeW'(sz);
                blk_link[blk] = rem;
            end
            blk_free[blk]    = 0;
            r.result_address = AddrW'(blk_base[blk] + HeaderBytes);
            r.status         = StOk;
            return r;
        endfunction

        function rsp_t release_block(logic [AddrW-1:0] addr);
            rsp_t r;
            int   cur;
            r   = '0;
            cur = head;
            if (addr == 0)
            begin
                r.status = StZero;
                return r;
            end
            for (int hops = 0; hops < MaxBlocks && cur < MaxBlocks; hops++)
            begin
                if (AddrW'(blk_base[cur] + HeaderBytes) == addr)
                begin
                    blk_free[cur] = 1;
                    r.status      = StOk;
                    return r;
                end
                cur = blk_link[cur];
            end
            r.status = StUnknown;
            return r;
        endfunction

        // accepted request transaction: predict and queue its response
        function rsp_t note_request(req_t req);
            rsp_t r;
            if (req.op == OpAlloc)
                r = allocate(longint'(req.request_size));
            else
                r = release_block(req.free_address);
            pending_rsp.push_back(r);
            return r;
        endfunction

        // accepted response transaction
        function void check_response(rsp_t got);
            rsp_t want;
            checked++;
            status_seen[got.status]++;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response addr %h status %0d",
                       got.result_address, got.status);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.result_address !== want.result_address)
            begin
                $error("result_address expected %h actual %h",
                       want.result_address, got.result_address);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    req_t        in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rsp_t        out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    heap_scoreboard sb = new();
    logic [AddrW-1:0] live_ptrs[$];
    int burst_left = 0;
    int sent = 0;
    int stall_mode = 0;

    first_fit_heap_allocator_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #50ms;
        $display("tb_first_fit_heap_allocator_core NOT OK");
        $finish;
    end

    // response side: check accepted transactions, stall in changing modes
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(out_data);
        if ($urandom_range(0, 99) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // drive one request in bursts with random gaps
    task automatic send_req(req_t req);
        rsp_t r;
        int   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = sb.note_request(req);
        if (req.op == OpAlloc && r.status == StOk)
            live_ptrs.push_back(r.result_address);
        burst_left--;
        sent++;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic reg_write(int idx, longint unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(8 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_t mk_alloc(logic [SizeW-1:0] size);
        req_t q;
        q.op           = OpAlloc;
        q.request_size = size;
        q.free_address = {16'($urandom), 32'($urandom)};
        return q;
    endfunction

    function automatic req_t mk_free(logic [AddrW-1:0] addr);
        req_t q;
        q.op           = OpFree;
        q.request_size = $urandom;
        q.free_address = addr;
        return q;
    endfunction

    function automatic req_t random_req();
        int pick, k;
        logic [AddrW-1:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            k = $urandom_range(0, 99);
            if (k < 70)      return mk_alloc($urandom_range(1, 256));
            else if (k < 90) return mk_alloc($urandom_range(257, 5000));
            else if (k < 97) return mk_alloc($urandom_range(5001, 40000));
            else             return mk_alloc($urandom);
        end
        if (pick < 90 && live_ptrs.size() != 0)
        begin
            k = $urandom_range(0, live_ptrs.size() - 1);
            a = live_ptrs[k];
            if ($urandom_range(0, 1) == 1)
                live_ptrs.delete(k);
            return mk_free(a);
        end
        if (pick < 93)
            return mk_free('0);
        return mk_free({16'($urandom), 32'($urandom)});
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_req(random_req());
    endtask

    // main sequence
    initial
    begin
        logic [AddrW-1:0] p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: special cases and field extremes
        send_req(mk_alloc(0));
        send_req(mk_free('0));
        send_req(mk_free({AddrW{1'b1}}));
        send_req(mk_alloc(1));
        send_req(mk_alloc(32'hFFFF_FFFF));
        send_req(mk_alloc(4072));
        send_req(mk_alloc(4073));
        send_req(mk_alloc(16));
        send_req(mk_alloc(17));
        p = live_ptrs[0];
        send_req(mk_free(p));
        send_req(mk_free(p));
        send_req(mk_alloc(8));
        send_req(mk_free(p + 1));
        send_req(mk_alloc(20000));
        send_req(mk_alloc(1048576));
        send_req(mk_alloc(2000000));
        random_phase(380);
        quiesce();

        // no frames available
        reg_write(RegRegionFrames, 0);
        reg_write(RegRegionBase, 4096);
        random_phase(200);
        quiesce();

        // region at the very top of the address space
        reg_write(RegRegionBase, 64'hFFFF_FFFF_F000);
        reg_write(RegRegionFrames, 1048576);
        random_phase(200);
        quiesce();

        reg_write(RegRegionBase, 64'h0000_2000_0000);
        reg_write(RegRegionFrames, 64'h1F_FFFF);
        random_phase(400);
        quiesce();

        $display("run covered %0d requests and %0d responses over four region settings",
                 sent, sb.checked);
        $display("status ok %0d zero %0d nomem %0d nodesc %0d unknown %0d",
                 sb.status_seen[StOk], sb.status_seen[StZero], sb.status_seen[StNoMem],
                 sb.status_seen[StNoDesc], sb.status_seen[StUnknown]);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("tb_first_fit_heap_allocator_core OK");
        else
            $display("tb_first_fit_heap_allocator_core NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
